>>> hdl/mp2w_pkg.sv
// Shared constants, types and helper functions of the 2-D max pooling block.
package mp2w_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLS    = 256;
  localparam int MAX_WINDOW  = 8;
  localparam int SAMPLE_BITS = 16;

  localparam int COL_BITS  = $clog2(MAX_COLS);
  localparam int BANK_BITS = $clog2(MAX_WINDOW);
  localparam int DIM_BITS  = 9;
  localparam int WIN_BITS  = 4;
  localparam int CFG_BITS  = 3;
  localparam int CFG_DATA_BITS = 9;

  // Configuration register indexes
  localparam logic [CFG_BITS-1:0] CFG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [CFG_BITS-1:0] CFG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_BITS-1:0] CFG_WINDOW_HEIGHT = 3'd2;
  localparam logic [CFG_BITS-1:0] CFG_WINDOW_WIDTH  = 3'd3;
  localparam logic [CFG_BITS-1:0] CFG_STEP_ROWS     = 3'd4;
  localparam logic [CFG_BITS-1:0] CFG_STEP_COLS     = 3'd5;
  localparam logic [CFG_BITS-1:0] CFG_SAME_PADDING  = 3'd6;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Column read token that walks down the chain of row banks
  typedef struct packed {
    logic                  vld;
    logic                  first;
    logic                  last;
    logic                  seen;
    logic [MAX_WINDOW-1:0] en;
    logic [COL_BITS-1:0]   col;
    sample_t               mx;
  } tok_t;

  // ceil(2^16 / s) for strides 1..8
  function automatic logic [16:0] recip(input logic [WIN_BITS-1:0] s);
    logic [16:0] r;
    case (s)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // floor(x / s) for x < 1024 and s in 1..8, exact by reciprocal multiply
  function automatic logic [9:0] div_small(input logic [9:0] x,
                                           input logic [WIN_BITS-1:0] s);
    logic [26:0] prod;
    prod = 27'(x) * 27'(recip(s));
    return prod[25:16];
  endfunction

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] hi);
    logic [DIM_BITS-1:0] r;
    if (v == '0) r = DIM_BITS'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [WIN_BITS-1:0] clamp_win(input logic [WIN_BITS-1:0] v);
    logic [WIN_BITS-1:0] r;
    if (v == '0) r = WIN_BITS'(1);
    else if (v > WIN_BITS'(MAX_WINDOW)) r = WIN_BITS'(MAX_WINDOW);
    else r = v;
    return r;
  endfunction

endpackage

>>> hdl/mp2w_in_if.sv
// Sample input channel: valid/ready handshake with one sample per word.
interface mp2w_in_if;
  logic              valid;
  logic              ready;
  mp2w_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> hdl/mp2w_out_if.sv
// Result channel: valid/ready handshake carrying one window maximum per word.
interface mp2w_out_if;
  logic              valid;
  logic              ready;
  mp2w_pkg::sample_t window_max;
  logic [7:0]        out_row;
  logic [7:0]        out_col;
  logic              last_of_run;
  logic              plane_done;

  modport source (output valid, output window_max, output out_row, output out_col,
                  output last_of_run, output plane_done, input ready);
  modport sink (input valid, input window_max, input out_row, input out_col,
                input last_of_run, input plane_done, output ready);
endinterface

>>> hdl/mp2w_ram.sv
// Generic simple dual-port RAM with registered read.
module mp2w_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/mp2w_cell.sv
// One chain cell: a row bank of the ring store plus a running max stage.
module mp2w_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [mp2w_pkg::COL_BITS-1:0] wr_addr,
  input  mp2w_pkg::sample_t             wr_data,
  input  mp2w_pkg::tok_t                tok_in,
  output mp2w_pkg::tok_t                tok_out
);

  mp2w_pkg::tok_t    tok_r;
  mp2w_pkg::sample_t rd_data;

  // Bank read starts as the token enters, data lines up with tok_r
  mp2w_ram #(
    .WIDTH (mp2w_pkg::SAMPLE_BITS),
    .DEPTH (mp2w_pkg::MAX_COLS)
  ) u_bank (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (tok_in.col),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  // Fold this bank's sample in when its row is inside the window
  always_comb begin
    tok_out    = tok_r;
    tok_out.en = tok_r.en >> 1;
    if (tok_r.vld && tok_r.en[0]) begin
      if (!tok_r.seen || (rd_data > tok_r.mx)) begin
        tok_out.mx   = rd_data;
        tok_out.seen = 1'b1;
      end
    end
  end

endmodule

>>> hdl/max_pool_2d_window.sv
// Top level of the 2-D max pooling block: geometry, window sequencing, cell chain.
//
// Usage: samples of one plane enter on in_ch in raster order; each word that
// completes one or more pooling windows yields one out_ch word per window, in
// row-major window order, carrying the window maximum, its output row and
// column, last_of_run on the final word of that sample and plane_done on the
// last window of the plane. Registers are written over cfg_we/cfg_index/
// cfg_wdata while the block is idle.
// Timing: one sample is handled at a time. A sample that finishes no window
// passes through the accept step and five geometry steps; every window it
// finishes adds the setup states WSET and MASK, one column read per window
// column, the chain of MAX_WINDOW row-bank cells and the column accumulator,
// and the emit state. The eight cell stages make up the bulk of that path.
// Reset: synchronous, active low; position goes to row 0, column 0, registers
// to their defaults. Store contents are not cleared. No word is taken in reset.
// Stalls: results leave through an output register; while the receiver holds
// ready low the sequencer waits before the next window, and a new sample is
// taken as soon as the last window word sits in the output register.
module max_pool_2d_window (
  input  logic                               clk,
  input  logic                               rst_n,
  mp2w_in_if.sink                            in_ch,
  mp2w_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [mp2w_pkg::CFG_BITS-1:0]      cfg_index,
  input  logic [mp2w_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int NW = mp2w_pkg::MAX_WINDOW;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_GEO1 = 11'b00000000010,
    S_GEO2 = 11'b00000000100,
    S_GEO3 = 11'b00000001000,
    S_GEO4 = 11'b00000010000,
    S_GEO5 = 11'b00000100000,
    S_WSET = 11'b00001000000,
    S_MASK = 11'b00010000000,
    S_SCAN = 11'b00100000000,
    S_WAIT = 11'b01000000000,
    S_EMIT = 11'b10000000000
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [mp2w_pkg::DIM_BITS-1:0] cfg_nh_r, cfg_nw_r;
  logic [mp2w_pkg::WIN_BITS-1:0] cfg_fh_r, cfg_fw_r, cfg_sh_r, cfg_sw_r;
  logic                          cfg_same_r;

  // Position of the next sample
  logic [7:0] pix_row_r, pix_col_r;

  // Per-dimension geometry, index 0 rows, index 1 columns
  logic [mp2w_pkg::DIM_BITS-1:0] n_r [2];
  logic [mp2w_pkg::WIN_BITS-1:0] f_r [2];
  logic [mp2w_pkg::WIN_BITS-1:0] s_r [2];
  logic [7:0]                    p_r [2];
  logic                          same_r;
  logic [8:0]                    qn_r [2];
  logic [2:0]                    pad_r [2];
  logic [1:0]                    off_r [2];
  logic signed [10:0]            span_r [2];
  logic signed [10:0]            t_r [2];
  logic [8:0]                    cnt_r [2];
  logic [8:0]                    tq_r [2];
  logic [8:0]                    tc_r [2];
  logic [7:0]                    kmin_r [2];
  logic [7:0]                    kmax_r [2];
  logic [7:0]                    klast_r [2];
  logic [7:0]                    k_r [2];
  logic [7:0]                    b_r [2];
  logic [7:0]                    e_r [2];

  logic [NW-1:0] mask_r;
  logic [7:0]    cc_r;

  // Geometry combinational terms
  logic [12:0]        qs_c [2];
  logic [8:0]         m_c [2];
  logic [3:0]         sub_c [2];
  logic [2:0]         pad_c [2];
  logic [10:0]        span_c [2];
  logic [10:0]        t_c [2];
  logic [10:0]        spanadj_c [2];
  logic [10:0]        tadj_c [2];
  logic [8:0]         cnt_c [2];
  logic [8:0]         tq_c [2];
  logic [8:0]         tc_c [2];
  logic [8:0]         nm1_c [2];
  logic [8:0]         kmin_c [2];
  logic [8:0]         kmax_c [2];
  logic               ok_c [2];
  logic [10:0]        ks_c [2];
  logic signed [11:0] bs_c [2];
  logic signed [11:0] es_c [2];
  logic [7:0]         bcl_c [2];
  logic [7:0]         ecl_c [2];
  logic [NW-1:0]      mask_c;
  logic [2:0]         dj_c;
  logic [7:0]         rspan_c;

  // Chain and result path
  mp2w_pkg::tok_t    head_tok;
  mp2w_pkg::tok_t    chain_w [NW+1];
  logic [NW-1:0]     bank_we;
  mp2w_pkg::sample_t acc_r;
  logic              acc_done_r;

  logic              out_valid_r;
  mp2w_pkg::sample_t out_max_r;
  logic [7:0]        out_row_r, out_col_r;
  logic              out_last_r, out_done_r;

  logic in_acc;
  logic out_free;

  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_nh_r   <= mp2w_pkg::DIM_BITS'(1);
      cfg_nw_r   <= mp2w_pkg::DIM_BITS'(1);
      cfg_fh_r   <= mp2w_pkg::WIN_BITS'(1);
      cfg_fw_r   <= mp2w_pkg::WIN_BITS'(1);
      cfg_sh_r   <= mp2w_pkg::WIN_BITS'(1);
      cfg_sw_r   <= mp2w_pkg::WIN_BITS'(1);
      cfg_same_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mp2w_pkg::CFG_IMAGE_HEIGHT:  cfg_nh_r   <= cfg_wdata;
        mp2w_pkg::CFG_IMAGE_WIDTH:   cfg_nw_r   <= cfg_wdata;
        mp2w_pkg::CFG_WINDOW_HEIGHT: cfg_fh_r   <= cfg_wdata[mp2w_pkg::WIN_BITS-1:0];
        mp2w_pkg::CFG_WINDOW_WIDTH:  cfg_fw_r   <= cfg_wdata[mp2w_pkg::WIN_BITS-1:0];
        mp2w_pkg::CFG_STEP_ROWS:     cfg_sh_r   <= cfg_wdata[mp2w_pkg::WIN_BITS-1:0];
        mp2w_pkg::CFG_STEP_COLS:     cfg_sw_r   <= cfg_wdata[mp2w_pkg::WIN_BITS-1:0];
        mp2w_pkg::CFG_SAME_PADDING:  cfg_same_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Geometry terms, both dimensions side by side
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      // padding from n mod s
      qs_c[d]  = 13'(qn_r[d]) * 13'(s_r[d]);
      m_c[d]   = n_r[d] - qs_c[d][8:0];
      sub_c[d] = (m_c[d] == '0) ? s_r[d] : m_c[d][3:0];
      pad_c[d] = (same_r && (f_r[d] > sub_c[d])) ? 3'(f_r[d] - sub_c[d]) : 3'd0;
      // span of window origins and end-aligned origin of this position
      span_c[d] = 11'(n_r[d]) + 11'(pad_r[d]) - 11'(f_r[d]) + 11'd1;
      t_c[d]    = 11'(p_r[d]) - 11'(f_r[d]) + 11'd1 + 11'(off_r[d]);
      // window count and quotients
      spanadj_c[d] = span_r[d] + 11'(s_r[d]) - 11'd1;
      tadj_c[d]    = t_r[d] + 11'(s_r[d]) - 11'd1;
      cnt_c[d] = (span_r[d] > 11'sd0) ?
                 9'(mp2w_pkg::div_small(spanadj_c[d][9:0], s_r[d])) : 9'd0;
      tq_c[d]  = 9'(mp2w_pkg::div_small(t_r[d][9:0], s_r[d]));
      tc_c[d]  = 9'(mp2w_pkg::div_small(tadj_c[d][9:0], s_r[d]));
      // range of windows whose clipped end is this position
      nm1_c[d] = n_r[d] - 9'd1;
      kmax_c[d] = cnt_r[d] - 9'd1;
      if ({1'b0, p_r[d]} == nm1_c[d]) begin
        kmin_c[d] = t_r[d][10] ? 9'd0 : tc_r[d];
        ok_c[d]   = (cnt_r[d] != '0) && (kmin_c[d] <= kmax_c[d]);
      end else if ({1'b0, p_r[d]} < nm1_c[d]) begin
        kmin_c[d] = tq_r[d];
        kmax_c[d] = tq_r[d];
        ok_c[d]   = !t_r[d][10] && (tq_r[d] == tc_r[d]) && (tq_r[d] < cnt_r[d]);
      end else begin
        kmin_c[d] = tq_r[d];
        ok_c[d]   = 1'b0;
      end
      // clipped extent of the current window
      ks_c[d]  = 11'(k_r[d]) * 11'(s_r[d]);
      bs_c[d]  = $signed(12'(ks_c[d]) - 12'(off_r[d]));
      es_c[d]  = bs_c[d] + $signed(12'(f_r[d])) - 12'sd1;
      bcl_c[d] = bs_c[d][11] ? 8'd0 : bs_c[d][7:0];
      ecl_c[d] = (es_c[d] > $signed({3'b000, nm1_c[d]})) ? nm1_c[d][7:0] : es_c[d][7:0];
    end
  end

  // Row banks that lie inside the window rows
  always_comb begin
    rspan_c = e_r[0] - b_r[0];
    dj_c    = '0;
    for (int j = 0; j < NW; j++) begin
      dj_c      = mp2w_pkg::BANK_BITS'(j) - b_r[0][mp2w_pkg::BANK_BITS-1:0];
      mask_c[j] = (8'(dj_c) <= rspan_c);
    end
  end

  // Geometry and window registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      n_r[0] <= mp2w_pkg::clamp_dim(cfg_nh_r, mp2w_pkg::DIM_BITS'(mp2w_pkg::MAX_ROWS));
      n_r[1] <= mp2w_pkg::clamp_dim(cfg_nw_r, mp2w_pkg::DIM_BITS'(mp2w_pkg::MAX_COLS));
      f_r[0] <= mp2w_pkg::clamp_win(cfg_fh_r);
      f_r[1] <= mp2w_pkg::clamp_win(cfg_fw_r);
      s_r[0] <= mp2w_pkg::clamp_win(cfg_sh_r);
      s_r[1] <= mp2w_pkg::clamp_win(cfg_sw_r);
      p_r[0] <= pix_row_r;
      p_r[1] <= pix_col_r;
      same_r <= cfg_same_r;
    end
    for (int d = 0; d < 2; d++) begin
      if (state_r == S_GEO1) begin
        qn_r[d] <= 9'(mp2w_pkg::div_small({1'b0, n_r[d]}, s_r[d]));
      end
      if (state_r == S_GEO2) begin
        pad_r[d] <= pad_c[d];
        off_r[d] <= pad_c[d][2:1];
      end
      if (state_r == S_GEO3) begin
        span_r[d] <= $signed(span_c[d]);
        t_r[d]    <= $signed(t_c[d]);
      end
      if (state_r == S_GEO4) begin
        cnt_r[d] <= cnt_c[d];
        tq_r[d]  <= tq_c[d];
        tc_r[d]  <= tc_c[d];
      end
      if (state_r == S_GEO5) begin
        kmin_r[d]  <= kmin_c[d][7:0];
        kmax_r[d]  <= kmax_c[d][7:0];
        klast_r[d] <= 8'(cnt_r[d] - 9'd1);
      end
      if (state_r == S_WSET) begin
        b_r[d] <= bcl_c[d];
        e_r[d] <= ecl_c[d];
      end
    end
    if (state_r == S_MASK) begin
      mask_r <= mask_c;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pix_row_r <= '0;
      pix_col_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_GEO1;
            // raster position, wrapped against the current plane size
            if (9'(pix_col_r) + 9'd1 >=
                mp2w_pkg::clamp_dim(cfg_nw_r, mp2w_pkg::DIM_BITS'(mp2w_pkg::MAX_COLS))) begin
              pix_col_r <= '0;
              if (9'(pix_row_r) + 9'd1 >=
                  mp2w_pkg::clamp_dim(cfg_nh_r, mp2w_pkg::DIM_BITS'(mp2w_pkg::MAX_ROWS))) begin
                pix_row_r <= '0;
              end else begin
                pix_row_r <= pix_row_r + 8'd1;
              end
            end else begin
              pix_col_r <= pix_col_r + 8'd1;
            end
          end
        end
        S_GEO1: state_r <= S_GEO2;
        S_GEO2: state_r <= S_GEO3;
        S_GEO3: state_r <= S_GEO4;
        S_GEO4: state_r <= S_GEO5;
        S_GEO5: begin
          k_r[0] <= kmin_c[0][7:0];
          k_r[1] <= kmin_c[1][7:0];
          state_r <= (ok_c[0] && ok_c[1]) ? S_WSET : S_IDLE;
        end
        S_WSET: state_r <= S_MASK;
        S_MASK: begin
          cc_r    <= b_r[1];
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          cc_r <= cc_r + 8'd1;
          if (cc_r == e_r[1]) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (acc_done_r) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (k_r[1] != kmax_r[1]) begin
              k_r[1]  <= k_r[1] + 8'd1;
              state_r <= S_WSET;
            end else if (k_r[0] != kmax_r[0]) begin
              k_r[0]  <= k_r[0] + 8'd1;
              k_r[1]  <= kmin_r[1];
              state_r <= S_WSET;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Column token into the head of the chain
  always_comb begin
    head_tok       = '0;
    head_tok.vld   = (state_r == S_SCAN);
    head_tok.first = (cc_r == b_r[1]);
    head_tok.last  = (cc_r == e_r[1]);
    head_tok.en    = mask_r;
    head_tok.col   = cc_r;
  end

  assign chain_w[0] = head_tok;

  // Row-bank cells, bank j holds rows with row mod MAX_WINDOW == j
  for (genvar i = 0; i < NW; i++) begin : g_cell
    assign bank_we[i] = in_acc &&
                        (pix_row_r[mp2w_pkg::BANK_BITS-1:0] == mp2w_pkg::BANK_BITS'(i));
    mp2w_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (bank_we[i]),
      .wr_addr (pix_col_r),
      .wr_data (in_ch.sample),
      .tok_in  (chain_w[i]),
      .tok_out (chain_w[i+1])
    );
  end

  // Horizontal max over the column words leaving the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_done_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && out_free) begin
        acc_done_r <= 1'b0;
      end
      if (chain_w[NW].vld && chain_w[NW].last) begin
        acc_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chain_w[NW].vld) begin
      if (chain_w[NW].first || (chain_w[NW].mx > acc_r)) begin
        acc_r <= chain_w[NW].mx;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_max_r  <= acc_r;
      out_row_r  <= k_r[0];
      out_col_r  <= k_r[1];
      out_last_r <= (k_r[0] == kmax_r[0]) && (k_r[1] == kmax_r[1]);
      out_done_r <= (k_r[0] == klast_r[0]) && (k_r[1] == klast_r[1]);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.window_max  = out_max_r;
  assign out_ch.out_row     = out_row_r;
  assign out_ch.out_col     = out_col_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.plane_done  = out_done_r;

`ifndef SYNTH
  a_chain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_w[NW].vld && chain_w[NW].last) |=> acc_done_r)
    else $error("last column word left the chain without completing the window");

  a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> acc_done_r)
    else $error("window emitted before its maximum was complete");

  a_mask_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (mask_r != '0))
    else $error("column scan with no row bank selected");
`endif

endmodule

>>> bench/tb_max_pool_2d_window.sv
// Self-checking testbench for the 2-D max pooling block: driver, monitor, window predictor.
module tb_max_pool_2d_window;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    mp2w_pkg::sample_t wmax;
    logic [7:0]        row;
    logic [7:0]        col;
    logic              last;
    logic              done;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mp2w_pkg::CFG_BITS-1:0] cfg_index = '0;
  logic [mp2w_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  mp2w_in_if in_if();
  mp2w_out_if out_if();

  max_pool_2d_window u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
  end

  // Shadow of the block: registers, row ring, position
  logic [8:0]        shadow_reg [7];
  mp2w_pkg::sample_t row_ring [mp2w_pkg::MAX_WINDOW][mp2w_pkg::MAX_COLS];
  int                pos_row = 0;
  int                pos_col = 0;

  mp2w_pkg::sample_t pending_samples[$];
  window_result_t    expected_windows[$];
  int  error_count = 0;
  int  results_seen = 0;
  int  samples_sent = 0;
  bit  no_idle = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  int  cycle_count = 0;

  function automatic int clamp_range(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Window count and leading offset along one axis
  function automatic void axis_geometry(input int n, input int f, input int s, input bit same,
                                        output int count, output int offset);
    int pad, m, sub, span;
    pad = 0;
    if (same) begin
      m = n % s;
      sub = (m == 0) ? s : m;
      pad = (f > sub) ? f - sub : 0;
    end
    offset = pad / 2;
    span = n + pad - f + 1;
    count = (span <= 0) ? 0 : (span + s - 1) / s;
  endfunction

  // Clipped span of window k; zero when empty
  function automatic bit window_span(input int k, input int n, input int f, input int s,
                                     input int offset, output int first, output int last);
    first = k * s - offset;
    last = first + f - 1;
    if (first < 0) first = 0;
    if (last > n - 1) last = n - 1;
    return first <= last;
  endfunction

  // Store one sample and queue every window it finishes
  function automatic void pool_sample(mp2w_pkg::sample_t s);
    int nh, nw, fh, fw, sh, sw, rcnt, ccnt, roff, coff, rb, re, cb, ce, produced;
    bit same;
    mp2w_pkg::sample_t best;
    window_result_t r;
    nh = clamp_range(shadow_reg[mp2w_pkg::CFG_IMAGE_HEIGHT], mp2w_pkg::MAX_ROWS);
    nw = clamp_range(shadow_reg[mp2w_pkg::CFG_IMAGE_WIDTH], mp2w_pkg::MAX_COLS);
    fh = clamp_range(shadow_reg[mp2w_pkg::CFG_WINDOW_HEIGHT], mp2w_pkg::MAX_WINDOW);
    fw = clamp_range(shadow_reg[mp2w_pkg::CFG_WINDOW_WIDTH], mp2w_pkg::MAX_WINDOW);
    sh = clamp_range(shadow_reg[mp2w_pkg::CFG_STEP_ROWS], mp2w_pkg::MAX_WINDOW);
    sw = clamp_range(shadow_reg[mp2w_pkg::CFG_STEP_COLS], mp2w_pkg::MAX_WINDOW);
    same = shadow_reg[mp2w_pkg::CFG_SAME_PADDING][0];
    produced = 0;
    if (pos_col < mp2w_pkg::MAX_COLS) row_ring[pos_row % mp2w_pkg::MAX_WINDOW][pos_col] = s;
    axis_geometry(nh, fh, sh, same, rcnt, roff);
    axis_geometry(nw, fw, sw, same, ccnt, coff);
    for (int kr = 0; kr < rcnt; kr++) begin
      if (!window_span(kr, nh, fh, sh, roff, rb, re) || re != pos_row) continue;
      for (int kc = 0; kc < ccnt; kc++) begin
        if (!window_span(kc, nw, fw, sw, coff, cb, ce) || ce != pos_col) continue;
        if (produced >= 64) continue;
        best = row_ring[rb % mp2w_pkg::MAX_WINDOW][cb];
        for (int y = rb; y <= re; y++)
          for (int x = cb; x <= ce; x++)
            if (row_ring[y % mp2w_pkg::MAX_WINDOW][x] > best)
              best = row_ring[y % mp2w_pkg::MAX_WINDOW][x];
        r.wmax = best;
        r.row = 8'(kr);
        r.col = 8'(kc);
        r.last = 1'b0;
        r.done = (kr == rcnt - 1) && (kc == ccnt - 1);
        expected_windows.push_back(r);
        produced++;
      end
    end
    if (produced > 0) expected_windows[expected_windows.size() - 1].last = 1'b1;
    if (pos_col + 1 >= nw) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= nh) ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int gap_length();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    error_count++;
  endtask

  // Sample driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pool_sample(in_if.sample);
        samples_sent++;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the word
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.sample <= pending_samples.pop_front();
        send_gap <= gap_length();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure
  int hold_cnt = 0;
  always @(posedge clk) begin
    window_result_t w;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_windows.size() == 0) begin
          report_mismatch("unexpected word, row", out_if.out_row, -1);
        end else begin
          w = expected_windows.pop_front();
          if (out_if.window_max !== w.wmax)
            report_mismatch("window_max", out_if.window_max, w.wmax);
          if (out_if.out_row !== w.row) report_mismatch("out_row", out_if.out_row, w.row);
          if (out_if.out_col !== w.col) report_mismatch("out_col", out_if.out_col, w.col);
          if (out_if.last_of_run !== w.last)
            report_mismatch("last_of_run", out_if.last_of_run, w.last);
          if (out_if.plane_done !== w.done)
            report_mismatch("plane_done", out_if.plane_done, w.done);
        end
      end
      if (hold_requests != holds_served) begin
        holds_served <= holds_served + 1;
        hold_cnt <= LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_if.ready <= 1'b0;
      end else begin
        hold_cnt <= gap_length();
        out_if.ready <= 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Write all registers back to back while the block is idle
  task automatic set_geometry(int ih, int iw, int wh, int ww, int sr, int sc, int same);
    int v [7];
    v = '{ih, iw, wh, ww, sr, sc, same};
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= mp2w_pkg::CFG_BITS'(i);
      cfg_wdata <= mp2w_pkg::CFG_DATA_BITS'(v[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_reg[mp2w_pkg::CFG_IMAGE_HEIGHT]  = 9'(ih);
    shadow_reg[mp2w_pkg::CFG_IMAGE_WIDTH]   = 9'(iw);
    shadow_reg[mp2w_pkg::CFG_WINDOW_HEIGHT] = 9'(wh & 15);
    shadow_reg[mp2w_pkg::CFG_WINDOW_WIDTH]  = 9'(ww & 15);
    shadow_reg[mp2w_pkg::CFG_STEP_ROWS]     = 9'(sr & 15);
    shadow_reg[mp2w_pkg::CFG_STEP_COLS]     = 9'(sc & 15);
    shadow_reg[mp2w_pkg::CFG_SAME_PADDING]  = 9'(same & 1);
  endtask

  function automatic mp2w_pkg::sample_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    return mp2w_pkg::sample_t'($urandom);
  endfunction

  // Queue one whole plane of the current geometry
  task automatic send_plane();
    int n;
    n = clamp_range(shadow_reg[mp2w_pkg::CFG_IMAGE_HEIGHT], mp2w_pkg::MAX_ROWS) *
        clamp_range(shadow_reg[mp2w_pkg::CFG_IMAGE_WIDTH], mp2w_pkg::MAX_COLS);
    for (int i = 0; i < n; i++) pending_samples.push_back(pick_sample());
  endtask

  // Wait for every word in flight, then the block's own latency
  task automatic drain();
    while (pending_samples.size() > 0 || in_if.valid || expected_windows.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_dim();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
  endfunction

  function automatic int pick_win();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
  endfunction

  initial begin
    shadow_reg = '{9'd1, 9'd1, 9'd1, 9'd1, 9'd1, 9'd1, 9'd0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry: every sample is its own window, sign extremes
    pending_samples = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
    drain();

    // Valid mode, rectangular window and strides
    set_geometry(4, 5, 2, 3, 1, 2, 0);
    send_plane();
    drain();

    // Same mode with clipped border windows, receiver held off for a long stretch
    set_geometry(5, 5, 3, 3, 2, 2, 1);
    hold_requests++;
    send_plane();
    drain();

    // Window larger than the image in valid mode: no results at all
    set_geometry(3, 3, 5, 5, 1, 1, 0);
    send_plane();
    drain();

    // Out-of-range values: zero height, zero window, oversize window width and strides
    set_geometry(0, 9, 0, 15, 15, 15, 1);
    no_idle = 1;
    send_plane();
    drain();
    no_idle = 0;

    // Tall single-column plane, widest window and stride
    set_geometry(20, 1, 8, 8, 8, 8, 0);
    send_plane();
    drain();

    // Random geometries and content
    while (samples_sent < 240) begin
      set_geometry(pick_dim(), pick_dim(), pick_win(), pick_win(), pick_win(), pick_win(),
                   $urandom_range(0, 1));
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) == 0) hold_requests++;
      repeat ($urandom_range(1, 2)) send_plane();
      drain();
    end

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
